/* hdl/perm_pkg.sv */
`default_nettype none

package perm_pkg;

   localparam int SEQ_W      = 12;
   localparam int SEQ_MODULUS = 4096;
   localparam int COUNT_W    = 13;
   localparam int SPAN_W     = 13;
   localparam int WIN_W      = 13;
   localparam int RATE_W     = 14;
   localparam int PROD_W     = COUNT_W + RATE_W;
   localparam int QUOT_STEPS = RATE_W;
   localparam int STEP_W     = 4;

   localparam logic [RATE_W-1:0]  RATE_SCALE   = 14'd10000;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 13'h1FFF;
   localparam logic [WIN_W-1:0]   WINDOW_RESET = 13'd100;

   // one closed window, waiting for its rate to be worked out
   typedef struct packed {
      logic [SPAN_W-1:0]  span;
      logic [COUNT_W-1:0] count;
   } perm_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } perm_queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_EMIT
   } perm_back_state_type;

endpackage

`default_nettype wire

/* hdl/packet_error_rate_meter_top.sv */
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tdata[11:0] sequence number
// rsp     | out | rsp_tvalid/rsp_tready | tdata error rate, received, spanned
// csr     | in  | csr_valid/csr_ready   | csr_data[12:0] window_length
//
// The front takes one packet per cycle while the queue of closed windows has room.
// A closed window passes through the back as take, multiply, 14 divide steps, emit;
// a clamped window skips the divider. The divider sets the rate.
// Reset is synchronous; window length returns to 100, start and count to zero.
// The result register frees the back as soon as rsp is taken; QUEUE_DEPTH
// windows may wait between front and back before req_tready drops.
`default_nettype none

module packet_error_rate_meter_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_data,     // window_length
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [11:0] sequence number, [15:12] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata     // [13:0] error_rate_hundredths,
                                          // [26:14] packets_received,
                                          // [39:27] packets_spanned
);
   import perm_pkg::*;

   perm_queue_status_type q_status;
   perm_entry_type        q_push_data;
   perm_entry_type        q_pop_data;
   logic                  q_push;
   logic                  q_pop;
   logic [RATE_W-1:0]     error_rate_hundredths;
   logic [COUNT_W-1:0]    packets_received;
   logic [SPAN_W-1:0]     packets_spanned;

   perm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .seq_num       (req_tdata[SEQ_W-1:0]),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_push_data   (q_push_data)
   );

   perm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   perm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_status              (q_status),
      .q_pop_data            (q_pop_data),
      .q_pop                 (q_pop),
      .rsp_tvalid            (rsp_tvalid),
      .rsp_tready            (rsp_tready),
      .error_rate_hundredths (error_rate_hundredths),
      .packets_received      (packets_received),
      .packets_spanned       (packets_spanned)
   );

   assign rsp_tdata = {packets_spanned, packets_received, error_rate_hundredths};

endmodule

`default_nettype wire

/* hdl/perm_front.sv */
`default_nettype none

module perm_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [perm_pkg::WIN_W-1:0]      csr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [perm_pkg::SEQ_W-1:0]      seq_num,
   input  wire perm_pkg::perm_queue_status_type q_status,
   output logic                                 q_push,
   output perm_pkg::perm_entry_type             q_push_data
);
   import perm_pkg::*;

   logic [WIN_W-1:0]   window_length_ff, window_length_in;
   logic [SEQ_W-1:0]   window_start_ff, window_start_in;
   logic [COUNT_W-1:0] received_count_ff, received_count_in;

   logic [COUNT_W-1:0] count_inc;
   logic [SEQ_W-1:0]   seq_diff;
   logic [SPAN_W-1:0]  span;
   logic               closing;
   logic               accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   assign count_inc = (received_count_ff == COUNT_MAX) ? received_count_ff
                                                       : received_count_ff + 1'b1;
   assign seq_diff  = seq_num - window_start_ff;
   assign span      = {{(SPAN_W-SEQ_W){1'b0}}, seq_diff} + 1'b1;
   assign closing   = (span >= window_length_ff);

   assign q_push            = accept && closing;
   assign q_push_data.span  = span;
   assign q_push_data.count = count_inc;

   always_comb begin
      window_length_in  = window_length_ff;
      window_start_in   = window_start_ff;
      received_count_in = received_count_ff;
      if (csr_valid && csr_ready) begin
         window_length_in = csr_data;
      end
      if (accept) begin
         if (closing) begin
            window_start_in   = seq_num + 1'b1;
            received_count_in = '0;
         end else begin
            received_count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_RESET;
         window_start_ff   <= '0;
         received_count_ff <= '0;
      end else begin
         window_length_ff  <= window_length_in;
         window_start_ff   <= window_start_in;
         received_count_ff <= received_count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/perm_queue.sv */
`default_nettype none

module perm_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire perm_pkg::perm_entry_type         push_data,
   input  wire logic                             pop,
   output perm_pkg::perm_entry_type              pop_data,
   output perm_pkg::perm_queue_status_type       status
);
   import perm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   perm_entry_type  mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign status.full      = (fill_ff == CW'(DEPTH));
   assign status.not_empty = (fill_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign pop_data         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("queue fill above depth");

   // front must hold off when the queue is full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full queue");

endmodule

`default_nettype wire

/* hdl/perm_back.sv */
`default_nettype none

module perm_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire perm_pkg::perm_queue_status_type  q_status,
   input  wire perm_pkg::perm_entry_type         q_pop_data,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [perm_pkg::RATE_W-1:0]           error_rate_hundredths,
   output logic [perm_pkg::COUNT_W-1:0]          packets_received,
   output logic [perm_pkg::SPAN_W-1:0]           packets_spanned
);
   import perm_pkg::*;

   perm_back_state_type state_ff, state_in;

   logic [COUNT_W-1:0] count_ff;
   logic [SPAN_W-1:0]  span_ff;
   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0]  dsh_ff, dsh_in;
   logic [RATE_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               clamp_ff, clamp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rate_ff;
   logic [COUNT_W-1:0] rcv_ff;
   logic [SPAN_W-1:0]  spn_ff;

   logic               take;
   logic               load_out;
   logic               fits;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fits     = (rem_ff >= dsh_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (q_status.not_empty) state_in = BK_MUL;
         BK_MUL:  state_in = (count_ff >= span_ff) ? BK_EMIT : BK_DIV;
         BK_DIV:  if (step_ff == STEP_W'(QUOT_STEPS-1)) state_in = BK_EMIT;
         BK_EMIT: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      take     = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: take = q_status.not_empty;
         BK_MUL:  ;
         BK_DIV:  ;
         BK_EMIT: load_out = out_free;
         default: ;
      endcase
   end

   assign q_pop = take;

   // shift-subtract divider: count < span keeps the quotient under 2**RATE_W
   always_comb begin
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      clamp_in = clamp_ff;
      unique case (state_ff)
         BK_MUL: begin
            rem_in   = PROD_W'(count_ff) * PROD_W'(RATE_SCALE);
            dsh_in   = PROD_W'(span_ff) << (QUOT_STEPS - 1);
            quot_in  = '0;
            step_in  = '0;
            clamp_in = (count_ff >= span_ff);
         end
         BK_DIV: begin
            if (fits) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in  = dsh_ff >> 1;
            quot_in = {quot_ff[RATE_W-2:0], fits};
            step_in = step_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         count_ff <= q_pop_data.count;
         span_ff  <= q_pop_data.span;
      end
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      clamp_ff <= clamp_in;
      if (load_out) begin
         rate_ff <= clamp_ff ? '0 : RATE_SCALE - quot_ff;
         rcv_ff  <= count_ff;
         spn_ff  <= span_ff;
      end
   end

   assign rsp_tvalid            = rsp_valid_ff;
   assign error_rate_hundredths = rate_ff;
   assign packets_received      = rcv_ff;
   assign packets_spanned       = spn_ff;

   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rate_ff <= RATE_SCALE))
      else $error("rate above full scale");

   // divider never runs past its last quotient bit
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (step_ff < STEP_W'(QUOT_STEPS)))
      else $error("divider step overrun");

endmodule

`default_nettype wire
